// ===== design/assert_macros.svh =====
// Assertion macros shared by the CORDIC sine/cosine RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check outside reset only.
`define CSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define CSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/csc_pkg.sv =====
// Package for the CORDIC sine/cosine unit: format constants, stage data type
// and the arctangent/gain table. No dependencies.
package csc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ITERATIONS = 16;
  localparam int DATA_W     = 32;
  localparam int SHIFT_W    = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

  localparam logic [63:0] DEC_SCALE = 64'd10000000000;

  // Decimal fraction scaled by 10^10, floored to FRAC_BITS fractional bits.
  function automatic logic [DATA_W-1:0] to_fixed(input logic [63:0] dec);
    logic [63:0] scaled;
    scaled = (dec << FRAC_BITS) / DEC_SCALE;
    return scaled[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] atan_fix(input int idx);
    logic [63:0] dec;
    case (idx)
      0:       dec = 64'd7853981600;
      1:       dec = 64'd4636476100;
      2:       dec = 64'd2449786600;
      3:       dec = 64'd1243549900;
      4:       dec = 64'd624188100;
      5:       dec = 64'd312398300;
      6:       dec = 64'd156237300;
      7:       dec = 64'd78123400;
      8:       dec = 64'd39062300;
      9:       dec = 64'd19531200;
      10:      dec = 64'd9765600;
      11:      dec = 64'd4882800;
      12:      dec = 64'd2441400;
      13:      dec = 64'd1220700;
      14:      dec = 64'd610400;
      15:      dec = 64'd305200;
      default: dec = 64'd0;
    endcase
    return to_fixed(dec);
  endfunction

  localparam logic [DATA_W-1:0] GAIN_FIX = to_fixed(64'd6072529350);

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic [DATA_W-1:0] theta;
  } csc_data_t;

endpackage

// ===== design/csc_cell.sv =====
// One CORDIC micro-rotation with its own pipeline register and handshake.
// Depends on csc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csc_cell
  import csc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [SHIFT_W-1:0]  shift_amt,
  input  logic [DATA_W-1:0]   atan_val,
  input  logic                in_valid,
  input  csc_data_t           in_data,
  output logic                in_stall,
  output logic                out_valid,
  output csc_data_t           out_data,
  input  logic                out_stall
);

  logic        valid_r;
  logic        valid_nxt;
  csc_data_t   data_r;
  csc_data_t   data_nxt;
  logic        advance;
  logic        rot_pos;
  logic [DATA_W-1:0] xs;
  logic [DATA_W-1:0] ys;

  // Advance when empty or when the neighbor takes our item.
  assign advance  = !valid_r || !out_stall;
  assign in_stall = !advance;

  always_comb begin
    rot_pos = $signed(in_data.theta) > $signed(in_data.z);
    xs      = DATA_W'($signed(in_data.x) >>> shift_amt);
    ys      = DATA_W'($signed(in_data.y) >>> shift_amt);
    data_nxt.theta = in_data.theta;
    if (rot_pos) begin
      data_nxt.x = in_data.x - ys;
      data_nxt.y = in_data.y + xs;
      data_nxt.z = in_data.z + atan_val;
    end else begin
      data_nxt.x = in_data.x + ys;
      data_nxt.y = in_data.y - xs;
      data_nxt.z = in_data.z - atan_val;
    end
  end

  assign valid_nxt = advance ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  `CSC_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !valid_r, "cell not empty after reset")
  `CSC_ASSERT(a_hold_on_stall, (valid_r && out_stall) |=> (valid_r && $stable(data_r)), "stalled item lost or changed")
  `CSC_ASSERT(a_take_lands, (in_valid && !in_stall) |=> valid_r, "accepted item dropped")

endmodule

// ===== design/cordic_sine_cosine_unit.sv =====
// CORDIC sine/cosine unit: top level, a chain of ITERATIONS csc_cell stages.
// Depends on csc_pkg and csc_cell.
//
// Takes one signed angle in radians (FRAC_BITS fractional bits, nominally
// -pi/2..pi/2) per transfer and returns its sine and cosine in the same
// format, one result per angle, in order. The unit accepts a new angle every
// cycle while in_stall is low; each angle passes through the ITERATIONS cells
// in order, one register per cell. Each cell performs one rotation-mode
// micro-rotation and owns a register with its own valid bit, so a stall at
// the output only backs up the chain as far as the first empty cell: bubbles
// are squeezed out and angles keep flowing in while a finished result waits.
// The last cell is the output register. x starts at the CORDIC gain
// 0.6072529350, y and the accumulated angle at zero; when the angle equals the
// accumulated angle the step rotates negatively. Angles outside the range
// converge to about +/-1.74 rad without any error indication. All arithmetic
// wraps at 32 bits.
module cordic_sine_cosine_unit
  import csc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [DATA_W-1:0]  in_angle,
  output logic               in_stall,
  output logic               out_valid,
  output logic [DATA_W-1:0]  out_sine,
  output logic [DATA_W-1:0]  out_cosine,
  input  logic               out_stall
);

  // Stage g feeds cell g; stage ITERATIONS is the output.
  logic      stg_valid [ITERATIONS+1];
  csc_data_t stg_data  [ITERATIONS+1];
  logic      stg_stall [ITERATIONS+1];

  // Seed the first cell: gain in x, zero in y and the accumulated angle.
  assign stg_valid[0]          = in_valid;
  assign stg_data[0].x         = GAIN_FIX;
  assign stg_data[0].y         = '0;
  assign stg_data[0].z         = '0;
  assign stg_data[0].theta     = in_angle;
  assign in_stall              = stg_stall[0];
  assign stg_stall[ITERATIONS] = out_stall;

  genvar g;
  generate
    for (g = 0; g < ITERATIONS; g++) begin : g_cell
      csc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_amt (SHIFT_W'(g)),
        .atan_val  (atan_fix(g)),
        .in_valid  (stg_valid[g]),
        .in_data   (stg_data[g]),
        .in_stall  (stg_stall[g]),
        .out_valid (stg_valid[g+1]),
        .out_data  (stg_data[g+1]),
        .out_stall (stg_stall[g+1])
      );
    end
  endgenerate

  // Sine is the final y, cosine the final x.
  assign out_valid  = stg_valid[ITERATIONS];
  assign out_sine   = stg_data[ITERATIONS].y;
  assign out_cosine = stg_data[ITERATIONS].x;

endmodule
